// ===== design/cmm_pkg.sv =====
package cmm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Configuration port
    localparam int SIZE_W = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
    localparam logic CFG_MATRIX_SIZE = 1'b0;
    localparam logic CFG_SQUARE_MODE = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COMPUTE,
        ST_DRAIN
    } state_t;

    // One complex element, real part in the low bits
    typedef struct packed {
        logic signed [31:0] im;
        logic signed [31:0] re;
    } cplx_t;

    // Control that travels with one A element along the cell row
    typedef struct packed {
        logic vld;
        logic first;
        logic lastk;
        logic rowlast;
    } hop_ctl_t;

    // One finished product element
    typedef struct packed {
        logic  sat;
        logic  last;
        cplx_t val;
    } res_t;

endpackage

// ===== design/cmm_cell.sv =====
module cmm_cell
    import cmm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int IDX       = 0,
    localparam int DEPTH    = MAX_DIM * MAX_DIM,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW       = $clog2(MAX_DIM + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  cplx_t         wr_data,
    input  logic [NW-1:0] n_eff,
    input  hop_ctl_t      hop_ctl_in,
    input  logic [AW-1:0] hop_kb_in,
    input  cplx_t         hop_a_in,
    output hop_ctl_t      hop_ctl_out,
    output logic [AW-1:0] hop_kb_out,
    output cplx_t         hop_a_out,
    output logic          res_vld,
    output res_t          res
);

    localparam logic signed [63:0] HALF    = (64'sd1 <<< FRAC_BITS) >>> 1;
    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [31:0] OUT_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] OUT_MIN = {1'b1, {31{1'b0}}};

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63]) begin
                sat_add = s[64] ? ACC_MIN : ACC_MAX;
            end else begin
                sat_add = s[63:0];
            end
        end
    endfunction

    // Right-operand copy for this column
    cplx_t mem [DEPTH];

    hop_ctl_t          hop_ctl_reg;
    logic [AW-1:0]     hop_kb_reg;
    cplx_t             hop_a_reg;
    hop_ctl_t          rd_ctl_reg;
    cplx_t             rd_a_reg;
    cplx_t             rd_b_reg;
    hop_ctl_t          mul_ctl_reg;
    logic signed [63:0] mul_rr_reg, mul_ii_reg, mul_ri_reg, mul_ir_reg;
    hop_ctl_t          rnd_ctl_reg;
    logic signed [63:0] rnd_rr_reg, rnd_ii_reg, rnd_ri_reg, rnd_ir_reg;
    logic signed [63:0] acc_re_reg, acc_im_reg;
    logic signed [63:0] acc_re_next, acc_im_next;
    logic              done_reg;
    logic              last_reg;
    logic [AW:0]       addr_sum;
    logic [AW-1:0]     rd_addr;
    logic              active;
    logic              sat_re, sat_im;

    assign addr_sum = {1'b0, hop_kb_reg} + (AW + 1)'(IDX);
    assign rd_addr  = addr_sum[AW-1:0];
    assign active   = NW'(IDX) < n_eff;

    // Pass the A element on to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_ctl_reg <= '0;
        end else begin
            hop_ctl_reg <= hop_ctl_in;
        end
        hop_kb_reg <= hop_kb_in;
        hop_a_reg  <= hop_a_in;
    end

    assign hop_ctl_out = hop_ctl_reg;
    assign hop_kb_out  = hop_kb_reg;
    assign hop_a_out   = hop_a_reg;

    // Store loaded elements, read B[k][col]
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_b_reg <= mem[rd_addr];
    end

    // Pipeline control: read, multiply, round
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ctl_reg  <= '0;
            mul_ctl_reg <= '0;
            rnd_ctl_reg <= '0;
        end else begin
            rd_ctl_reg     <= hop_ctl_reg;
            rd_ctl_reg.vld <= hop_ctl_reg.vld && active;
            mul_ctl_reg    <= rd_ctl_reg;
            rnd_ctl_reg    <= mul_ctl_reg;
        end
    end

    // Four partial products, then round half up
    always_ff @(posedge aclk) begin
        rd_a_reg   <= hop_a_reg;
        mul_rr_reg <= rd_a_reg.re * rd_b_reg.re;
        mul_ii_reg <= rd_a_reg.im * rd_b_reg.im;
        mul_ri_reg <= rd_a_reg.re * rd_b_reg.im;
        mul_ir_reg <= rd_a_reg.im * rd_b_reg.re;
        rnd_rr_reg <= (mul_rr_reg + HALF) >>> FRAC_BITS;
        rnd_ii_reg <= (mul_ii_reg + HALF) >>> FRAC_BITS;
        rnd_ri_reg <= (mul_ri_reg + HALF) >>> FRAC_BITS;
        rnd_ir_reg <= (mul_ir_reg + HALF) >>> FRAC_BITS;
    end

    // Saturating accumulate, restart on the first term of a row
    always_comb begin
        logic signed [63:0] base_re;
        logic signed [63:0] base_im;
        base_re     = rnd_ctl_reg.first ? '0 : acc_re_reg;
        base_im     = rnd_ctl_reg.first ? '0 : acc_im_reg;
        acc_re_next = sat_add(sat_add(base_re, rnd_rr_reg), -rnd_ii_reg);
        acc_im_next = sat_add(sat_add(base_im, rnd_ri_reg), rnd_ir_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= rnd_ctl_reg.vld && rnd_ctl_reg.lastk;
        end
        if (rnd_ctl_reg.vld) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
        last_reg <= rnd_ctl_reg.rowlast && (NW'(IDX) == n_eff - NW'(1));
    end

    // Clip to 32 bits
    assign sat_re = (acc_re_reg[63:31] != '0) && (acc_re_reg[63:31] != '1);
    assign sat_im = (acc_im_reg[63:31] != '0) && (acc_im_reg[63:31] != '1);

    always_comb begin
        res.val.re = sat_re ? (acc_re_reg[63] ? OUT_MIN : OUT_MAX) : acc_re_reg[31:0];
        res.val.im = sat_im ? (acc_im_reg[63] ? OUT_MIN : OUT_MAX) : acc_im_reg[31:0];
        res.sat    = sat_re || sat_im;
        res.last   = last_reg;
    end

    assign res_vld = done_reg;

endmodule

// ===== design/cmm_rq.sv =====
module cmm_rq
    import cmm_pkg::*;
#(
    parameter int DEPTH = 2 * MAX_DIM_DEF,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  res_t wr_data,
    output logic out_vld,
    input  logic out_rdy,
    output res_t out_data
);

    res_t          q [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign out_vld  = count_reg != '0;
    assign out_data = q[rd_ptr_reg];
    assign pop      = out_vld && out_rdy;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(wr_en) - CW'(pop);
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            q[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/complex_square_matrix_multiply.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// cfg      | in        | cfg_wr_en          | cfg_wr_index, cfg_wr_data
// s        | in        | s_tvalid/s_tready  | s_tdata: elem_real, elem_imag
// m        | out       | m_tvalid/m_tready  | m_tdata: out_real, out_imag; m_tuser: saturated; m_tlast
//
// Items load while s_tready is high, which is only while matrices load.
// After the item that completes the last matrix, A rows stream through a row of
// MAX_DIM column cells (the first n active), one k per cycle while issue is not
// stalled; results leave the queue at one item per cycle while m_tready is high.
// A new row enters only if the result queue (2*MAX_DIM entries) has room for it,
// so m_tready low stalls issue without losing items. Reset is synchronous, low.
module complex_square_matrix_multiply
    import cmm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_index,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [31:0] elem_real, [63:32] elem_imag
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // [31:0] out_real, [63:32] out_imag
    output logic              m_tuser,   // [0] saturated
    output logic              m_tlast
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW     = $clog2(MAX_DIM + 1);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int QDEPTH = 2 * MAX_DIM;
    localparam int QCW    = $clog2(QDEPTH + 1);

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic              square_reg;
    logic [NW-1:0]     n_eff;
    logic [NW-1:0]     n_run_reg, n_run_next;
    logic [CW-1:0]     total;
    logic [CW-1:0]     load_cnt_reg, load_cnt_next;
    logic [CW-1:0]     cnt_inc;
    logic              loading_right_reg, loading_right_next;
    logic              in_acc;
    cplx_t             elem;
    cplx_t             lmem [DEPTH];
    cplx_t             lmem_rd_reg;
    logic [AW:0]       lmem_sum;
    logic [NW-1:0]     row_reg, row_next;
    logic [NW-1:0]     k_reg, k_next;
    logic [AW-1:0]     abase_reg, abase_next;
    logic [AW-1:0]     kbase_reg, kbase_next;
    logic              fire;
    hop_ctl_t          is_ctl_reg;
    logic [AW-1:0]     is_kb_reg;
    logic [QCW-1:0]    credit_reg, credit_next;
    logic [QCW:0]      credit_need;
    logic              q_wr;
    res_t              q_data;
    res_t              q_out;
    logic              m_acc;

    hop_ctl_t          hop_ctl_w [MAX_DIM+1];
    logic [AW-1:0]     hop_kb_w  [MAX_DIM+1];
    cplx_t             hop_a_w   [MAX_DIM+1];
    logic [MAX_DIM-1:0] res_vld_vec;
    res_t              res_arr [MAX_DIM];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= SIZE_RESET;
            square_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MATRIX_SIZE: size_reg   <= cfg_wr_data;
                CFG_SQUARE_MODE: square_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the size to 1..MAX_DIM
    always_comb begin
        if (size_reg == '0) begin
            n_eff = NW'(1);
        end else if (size_reg > SIZE_W'(MAX_DIM)) begin
            n_eff = NW'(MAX_DIM);
        end else begin
            n_eff = NW'(size_reg);
        end
    end

    assign total   = CW'(n_eff) * CW'(n_eff);
    assign elem    = s_tdata;
    assign s_tready = state_reg == ST_LOAD;
    assign in_acc  = s_tvalid && s_tready;
    assign cnt_inc = load_cnt_reg + CW'(1);

    // Issue gate: a row starts only when the queue can take all of it
    assign credit_need = {1'b0, credit_reg} + (QCW + 1)'(n_run_reg);
    assign fire = (state_reg == ST_COMPUTE) &&
                  ((k_reg != '0) || (credit_need <= (QCW + 1)'(QDEPTH)));
    assign m_acc = m_tvalid && m_tready;

    // Next state, load counters and issue counters
    always_comb begin
        state_next         = state_reg;
        load_cnt_next      = load_cnt_reg;
        loading_right_next = loading_right_reg;
        n_run_next         = n_run_reg;
        row_next           = row_reg;
        k_next             = k_reg;
        abase_next         = abase_reg;
        kbase_next         = kbase_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    load_cnt_next = cnt_inc;
                    if (cnt_inc >= total) begin
                        load_cnt_next = '0;
                        if (!loading_right_reg && !square_reg) begin
                            loading_right_next = 1'b1;
                        end else begin
                            loading_right_next = 1'b0;
                            n_run_next         = n_eff;
                            row_next           = '0;
                            k_next             = '0;
                            abase_next         = '0;
                            kbase_next         = '0;
                            state_next         = ST_COMPUTE;
                        end
                    end
                end
            end
            ST_COMPUTE: begin
                if (fire) begin
                    if (k_reg == n_run_reg - NW'(1)) begin
                        k_next     = '0;
                        kbase_next = '0;
                        row_next   = row_reg + NW'(1);
                        abase_next = abase_reg + AW'(n_run_reg);
                        if (row_reg == n_run_reg - NW'(1)) begin
                            state_next = ST_DRAIN;
                        end
                    end else begin
                        k_next     = k_reg + NW'(1);
                        kbase_next = kbase_reg + AW'(n_run_reg);
                    end
                end
            end
            ST_DRAIN: begin
                if (credit_reg == '0) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_LOAD;
            load_cnt_reg      <= '0;
            loading_right_reg <= 1'b0;
            credit_reg        <= '0;
            is_ctl_reg        <= '0;
        end else begin
            state_reg         <= state_next;
            load_cnt_reg      <= load_cnt_next;
            loading_right_reg <= loading_right_next;
            credit_reg        <= credit_next;
            is_ctl_reg.vld     <= fire;
            is_ctl_reg.first   <= k_reg == '0;
            is_ctl_reg.lastk   <= k_reg == n_run_reg - NW'(1);
            is_ctl_reg.rowlast <= row_reg == n_run_reg - NW'(1);
        end
        n_run_reg <= n_run_next;
        row_reg   <= row_next;
        k_reg     <= k_next;
        abase_reg <= abase_next;
        kbase_reg <= kbase_next;
        is_kb_reg <= kbase_reg;
    end

    // Reserve queue room per row, release per delivered item
    assign credit_next = credit_reg + ((fire && (k_reg == '0)) ? QCW'(n_run_reg) : '0)
                         - QCW'(m_acc);

    // Left matrix store, read A[row][k]
    assign lmem_sum = {1'b0, abase_reg} + (AW + 1)'(k_reg);

    always_ff @(posedge aclk) begin
        if (in_acc && !loading_right_reg) begin
            lmem[load_cnt_reg[AW-1:0]] <= elem;
        end
        lmem_rd_reg <= lmem[lmem_sum[AW-1:0]];
    end

    assign hop_ctl_w[0] = is_ctl_reg;
    assign hop_kb_w[0]  = is_kb_reg;
    assign hop_a_w[0]   = lmem_rd_reg;

    // Row of column cells
    for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
        cmm_cell #(
            .MAX_DIM   (MAX_DIM),
            .FRAC_BITS (FRAC_BITS),
            .IDX       (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .wr_en       (in_acc),
            .wr_addr     (load_cnt_reg[AW-1:0]),
            .wr_data     (elem),
            .n_eff       (n_run_reg),
            .hop_ctl_in  (hop_ctl_w[i]),
            .hop_kb_in   (hop_kb_w[i]),
            .hop_a_in    (hop_a_w[i]),
            .hop_ctl_out (hop_ctl_w[i+1]),
            .hop_kb_out  (hop_kb_w[i+1]),
            .hop_a_out   (hop_a_w[i+1]),
            .res_vld     (res_vld_vec[i]),
            .res         (res_arr[i])
        );
    end

    // At most one cell finishes per cycle
    always_comb begin
        q_wr   = |res_vld_vec;
        q_data = res_arr[0];
        for (int i = 0; i < MAX_DIM; i++) begin
            if (res_vld_vec[i]) begin
                q_data = res_arr[i];
            end
        end
    end

    cmm_rq #(
        .DEPTH (QDEPTH)
    ) u_rq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_data  (q_data),
        .out_vld  (m_tvalid),
        .out_rdy  (m_tready),
        .out_data (q_out)
    );

    assign m_tdata = q_out.val;
    assign m_tuser = q_out.sat;
    assign m_tlast = q_out.last;

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= QCW'(QDEPTH))
        else $error("queue reservation exceeds queue depth");

    a_one_finisher: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(res_vld_vec))
        else $error("two cells finished in the same cycle");

    a_no_result_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (|res_vld_vec) |-> (state_reg != ST_LOAD))
        else $error("cell result while loading");

    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && state_next == ST_LOAD) |=> !m_tvalid)
        else $error("items left in queue after drain");

endmodule
